// ----- hw/rtl/isrt_pkg.sv -----
// Shared constants, codes, command and status types and the sieve prime table.
`default_nettype none
package isrt_pkg;

	localparam int NUM_PRIMES_DEF   = 64;
	localparam int RESIDUE_BITS_DEF = 9;
	localparam int PRIME_W          = 11;
	localparam int TBL_DEPTH        = 256;
	localparam int TBL_IDX_W        = 8;
	localparam int STEP_W           = 32;
	localparam int APB_DW           = 32;
	localparam int PADDR_W          = 3;
	localparam int CAND_STEP        = 2;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_STEP = 1'b1
	} req_t;

	typedef enum logic [0:0] {
		REG_ACTIVE_PRIMES = 1'b0
	} cfg_reg_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic sweep;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic out_busy;
	} dp_sts_t;

	localparam logic [PRIME_W-1:0] PRIME_TABLE [TBL_DEPTH] = '{
		11'd2, 11'd3, 11'd5, 11'd7, 11'd11, 11'd13, 11'd17, 11'd19,
		11'd23, 11'd29, 11'd31, 11'd37, 11'd41, 11'd43, 11'd47, 11'd53,
		11'd59, 11'd61, 11'd67, 11'd71, 11'd73, 11'd79, 11'd83, 11'd89,
		11'd97, 11'd101, 11'd103, 11'd107, 11'd109, 11'd113, 11'd127, 11'd131,
		11'd137, 11'd139, 11'd149, 11'd151, 11'd157, 11'd163, 11'd167, 11'd173,
		11'd179, 11'd181, 11'd191, 11'd193, 11'd197, 11'd199, 11'd211, 11'd223,
		11'd227, 11'd229, 11'd233, 11'd239, 11'd241, 11'd251, 11'd257, 11'd263,
		11'd269, 11'd271, 11'd277, 11'd281, 11'd283, 11'd293, 11'd307, 11'd311,
		11'd313, 11'd317, 11'd331, 11'd337, 11'd347, 11'd349, 11'd353, 11'd359,
		11'd367, 11'd373, 11'd379, 11'd383, 11'd389, 11'd397, 11'd401, 11'd409,
		11'd419, 11'd421, 11'd431, 11'd433, 11'd439, 11'd443, 11'd449, 11'd457,
		11'd461, 11'd463, 11'd467, 11'd479, 11'd487, 11'd491, 11'd499, 11'd503,
		11'd509, 11'd521, 11'd523, 11'd541, 11'd547, 11'd557, 11'd563, 11'd569,
		11'd571, 11'd577, 11'd587, 11'd593, 11'd599, 11'd601, 11'd607, 11'd613,
		11'd617, 11'd619, 11'd631, 11'd641, 11'd643, 11'd647, 11'd653, 11'd659,
		11'd661, 11'd673, 11'd677, 11'd683, 11'd691, 11'd701, 11'd709, 11'd719,
		11'd727, 11'd733, 11'd739, 11'd743, 11'd751, 11'd757, 11'd761, 11'd769,
		11'd773, 11'd787, 11'd797, 11'd809, 11'd811, 11'd821, 11'd823, 11'd827,
		11'd829, 11'd839, 11'd853, 11'd857, 11'd859, 11'd863, 11'd877, 11'd881,
		11'd883, 11'd887, 11'd907, 11'd911, 11'd919, 11'd929, 11'd937, 11'd941,
		11'd947, 11'd953, 11'd967, 11'd971, 11'd977, 11'd983, 11'd991, 11'd997,
		11'd1009, 11'd1013, 11'd1019, 11'd1021, 11'd1031, 11'd1033, 11'd1039, 11'd1049,
		11'd1051, 11'd1061, 11'd1063, 11'd1069, 11'd1087, 11'd1091, 11'd1093, 11'd1097,
		11'd1103, 11'd1109, 11'd1117, 11'd1123, 11'd1129, 11'd1151, 11'd1153, 11'd1163,
		11'd1171, 11'd1181, 11'd1187, 11'd1193, 11'd1201, 11'd1213, 11'd1217, 11'd1223,
		11'd1229, 11'd1231, 11'd1237, 11'd1249, 11'd1259, 11'd1277, 11'd1279, 11'd1283,
		11'd1289, 11'd1291, 11'd1297, 11'd1301, 11'd1303, 11'd1307, 11'd1319, 11'd1321,
		11'd1327, 11'd1361, 11'd1367, 11'd1373, 11'd1381, 11'd1399, 11'd1409, 11'd1423,
		11'd1427, 11'd1429, 11'd1433, 11'd1439, 11'd1447, 11'd1451, 11'd1453, 11'd1459,
		11'd1471, 11'd1481, 11'd1483, 11'd1487, 11'd1489, 11'd1493, 11'd1499, 11'd1511,
		11'd1523, 11'd1531, 11'd1543, 11'd1549, 11'd1553, 11'd1559, 11'd1567, 11'd1571,
		11'd1579, 11'd1583, 11'd1597, 11'd1601, 11'd1607, 11'd1609, 11'd1613, 11'd1619
	};

endpackage
`default_nettype wire

// ----- hw/rtl/isrt_if.sv -----
// Request and result channel interfaces.
`default_nettype none
interface isrt_in_if #(
	parameter int IDX_W = $clog2(isrt_pkg::NUM_PRIMES_DEF),
	parameter int RES_W = isrt_pkg::RESIDUE_BITS_DEF
);
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [IDX_W-1:0] prime_index;
	logic [RES_W-1:0] residue_value;

	modport source (output valid, req_type, prime_index, residue_value, input ready);
	modport sink (input valid, req_type, prime_index, residue_value, output ready);
endinterface

interface isrt_out_if;
	logic                          valid;
	logic                          ready;
	logic                          has_zero;
	logic [isrt_pkg::STEP_W-1:0]   step_count;
	logic                          status;

	modport source (output valid, has_zero, step_count, status, input ready);
	modport sink (input valid, has_zero, step_count, status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/isrt_ctrl.sv -----
// Sequencing state machine: capture, load check, residue sweep, result hand-off.
`default_nettype none
module isrt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              req_type,
	output logic                   in_ready,
	output isrt_pkg::dp_cmd_t      cmd,
	input  wire isrt_pkg::dp_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOAD  = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		cmd.capture = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = (req_type == isrt_pkg::REQ_STEP) ? ST_SWEEP : ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load  = 1'b1;
				state_nxt = ST_SWEEP;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOAD || state_q == ST_SWEEP))
		else $error("accepted request did not start work");

endmodule
`default_nettype wire

// ----- hw/rtl/isrt_dp.sv -----
// Residue memory, add-and-reduce unit, step counter and result register.
`default_nettype none
module isrt_dp #(
	parameter int NUM_PRIMES   = isrt_pkg::NUM_PRIMES_DEF,
	parameter int RESIDUE_BITS = isrt_pkg::RESIDUE_BITS_DEF,
	localparam int IDX_W       = $clog2(NUM_PRIMES),
	localparam int CNT_W       = $clog2(NUM_PRIMES + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire isrt_pkg::dp_cmd_t              cmd,
	output isrt_pkg::dp_sts_t                   sts,
	input  wire logic [CNT_W-1:0]               active_primes,
	input  wire logic                           req_type,
	input  wire logic [IDX_W-1:0]               prime_index,
	input  wire logic [RESIDUE_BITS-1:0]        residue_value,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic                                has_zero,
	output logic [isrt_pkg::STEP_W-1:0]         step_count,
	output logic                                status
);

	localparam int RES_W = RESIDUE_BITS;
	localparam int TW    = isrt_pkg::TBL_IDX_W;
	localparam int PW    = isrt_pkg::PRIME_W;
	localparam int CW    = (RES_W + 1 > PW) ? RES_W + 1 : PW;
	localparam int SW    = isrt_pkg::STEP_W;

	logic [RES_W-1:0] mem [NUM_PRIMES];
	logic             ent_valid_q [NUM_PRIMES];

	logic             req_q;
	logic [IDX_W-1:0] idx_q;
	logic [RES_W-1:0] val_q;
	logic             status_q;
	logic             zero_q;
	logic [SW-1:0]    step_cnt_q;
	logic [CNT_W-1:0] rd_ptr_q;

	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [RES_W-1:0] rdata_s1;
	logic             ent_vld_s1;

	logic             out_valid_q;
	logic             out_zero_q;
	logic [SW-1:0]    out_step_q;
	logic             out_status_q;

	logic [CNT_W-1:0] n_eff;
	logic             rd_more;
	logic             load_ok;
	logic [RES_W-1:0] cur_val;
	logic [CW-1:0]    prime_s1;
	logic [CW-1:0]    sum_s1;
	logic [CW-1:0]    red_s1;
	logic [RES_W-1:0] new_val;
	logic             advance;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [RES_W-1:0] wr_data;
	logic [IDX_W-1:0] rd_addr;

	always_comb begin
		if (active_primes < CNT_W'(2)) begin
			n_eff = CNT_W'(2);
		end else if (active_primes > CNT_W'(NUM_PRIMES)) begin
			n_eff = CNT_W'(NUM_PRIMES);
		end else begin
			n_eff = active_primes;
		end
	end

	assign rd_more = rd_ptr_q < n_eff;
	assign rd_addr = rd_ptr_q[IDX_W-1:0];
	assign load_ok = (CNT_W'(idx_q) < n_eff)
		&& (CW'(val_q) < CW'(isrt_pkg::PRIME_TABLE[TW'(idx_q)]));

	assign cur_val  = ent_vld_s1 ? rdata_s1 : '0;
	assign prime_s1 = CW'(isrt_pkg::PRIME_TABLE[TW'(idx_s1)]);
	assign sum_s1   = CW'(cur_val) + CW'(isrt_pkg::CAND_STEP);
	assign red_s1   = (sum_s1 >= prime_s1) ? (sum_s1 - prime_s1) : sum_s1;
	assign advance  = (req_q == isrt_pkg::REQ_STEP) && (idx_s1 != '0);
	assign new_val  = advance ? RES_W'(red_s1) : cur_val;

	always_comb begin
		if (cmd.load) begin
			wr_en   = load_ok;
			wr_addr = idx_q;
			wr_data = val_q;
		end else begin
			wr_en   = cmd.sweep && vld_s1 && advance;
			wr_addr = idx_s1;
			wr_data = new_val;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PRIMES; i++) begin
				ent_valid_q[i] <= 1'b0;
			end
		end else if (wr_en) begin
			ent_valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			idx_q <= prime_index;
			val_q <= residue_value;
		end
		if (cmd.sweep) begin
			idx_s1     <= rd_addr;
			ent_vld_s1 <= ent_valid_q[rd_addr];
		end
		if (cmd.emit) begin
			out_zero_q   <= zero_q;
			out_step_q   <= step_cnt_q;
			out_status_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= 1'b0;
			zero_q      <= 1'b0;
			step_cnt_q  <= '0;
			rd_ptr_q    <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				status_q <= 1'b0;
				zero_q   <= 1'b0;
				rd_ptr_q <= '0;
				vld_s1   <= 1'b0;
				if (req_type == isrt_pkg::REQ_STEP && step_cnt_q != '1) begin
					step_cnt_q <= step_cnt_q + SW'(1);
				end
			end
			if (cmd.load) begin
				status_q <= !load_ok;
			end
			if (cmd.sweep) begin
				vld_s1 <= rd_more;
				if (rd_more) begin
					rd_ptr_q <= rd_ptr_q + CNT_W'(1);
				end
				if (vld_s1 && new_val == '0) begin
					zero_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.sweep_done = !rd_more && !vld_s1;
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign has_zero   = out_zero_q;
	assign step_count = out_step_q;
	assign status     = out_status_q;

	a_emit_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("result register not loaded on emit");

	a_step_no_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep && req_q == isrt_pkg::REQ_STEP) |-> !status_q)
		else $error("step transaction carries reject status");

	a_prime2_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !cmd.load) |-> (wr_addr != '0))
		else $error("sweep wrote the residue for prime 2");

	a_step_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		step_cnt_q >= $past(step_cnt_q))
		else $error("step count went backwards");

endmodule
`default_nettype wire

// ----- hw/rtl/incremental_sieve_residue_tracker_unit.sv -----
// Top level: channels, configuration register port, controller and datapath.
//
//  channel   dir  kind            payload
//  in_ch     in   valid/ready     req_type, prime_index, residue_value
//  out_ch    out  valid/ready     has_zero, step_count, status
//  apb       in   psel/penable    active_primes at byte address 0
//
// Each sweep visits n residues; a load first checks and writes its entry. n is
// active_primes clamped to 2..NUM_PRIMES. The next transaction is taken after hand-off.
// The residue memory's single read port visits one entry per cycle.
// Reset needs no clearing pass: per-entry valid flags make unwritten residues read as 0.
// A finished result sits in the output register; the next transaction is taken
// meanwhile, and waits before its own hand-off until that register is free.
`default_nettype none
module incremental_sieve_residue_tracker_unit #(
	parameter int NUM_PRIMES   = isrt_pkg::NUM_PRIMES_DEF,
	parameter int RESIDUE_BITS = isrt_pkg::RESIDUE_BITS_DEF,
	localparam int CNT_W       = $clog2(NUM_PRIMES + 1)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	isrt_in_if.sink                               in_ch,
	isrt_out_if.source                            out_ch,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [isrt_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [isrt_pkg::APB_DW-1:0]      pwdata,
	output logic [isrt_pkg::APB_DW-1:0]           prdata,
	output logic                                  pready
);

	logic [CNT_W-1:0]   active_q;
	logic               reg_hit;
	isrt_pkg::dp_cmd_t  cmd;
	isrt_pkg::dp_sts_t  sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == isrt_pkg::REG_ACTIVE_PRIMES);
	assign prdata  = reg_hit ? isrt_pkg::APB_DW'(active_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CNT_W'(NUM_PRIMES);
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			active_q <= pwdata[CNT_W-1:0];
		end
	end

	isrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.req_type (in_ch.req_type),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	isrt_dp #(
		.NUM_PRIMES   (NUM_PRIMES),
		.RESIDUE_BITS (RESIDUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.active_primes (active_q),
		.req_type      (in_ch.req_type),
		.prime_index   (in_ch.prime_index),
		.residue_value (in_ch.residue_value),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.has_zero      (out_ch.has_zero),
		.step_count    (out_ch.step_count),
		.status        (out_ch.status)
	);

endmodule
`default_nettype wire
